// ===== hdl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  // Fixed field widths on the stream ports
  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int COL_FW = 7;
  localparam int ROW_FW = 5;
  localparam int POS_W  = 11;

  // Row operand of the address unit covers both the cursor and the field
  localparam int UROW_W = (ROW_W > ROW_FW) ? ROW_W : ROW_FW;

  localparam logic [CELL_W-1:0] ATTR_WORD    = 16'h0700;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  typedef enum logic [OP_W-1:0] {
    OP_PRINT  = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_SETCUR = 3'd2,
    OP_PROMPT = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef struct packed {
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
    logic [CHAR_W-1:0] ch;
    logic [OP_W-1:0]   op;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] data;
    logic [POS_W-1:0]  pos;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/tcw_addr_unit.sv =====
`default_nettype none

// Shared cell address unit: row * COLUMNS + base
module tcw_addr_unit
  import tcw_pkg::*;
(
  input  wire logic [UROW_W-1:0] row_i,
  input  wire logic [ADDR_W-1:0] base_i,
  output logic      [ADDR_W-1:0] idx_o
);

  assign idx_o = ADDR_W'(row_i) * ADDR_W'(COLUMNS) + base_i;

endmodule

`default_nettype wire

// ===== hdl/tcw_screen_ram.sv =====
`default_nettype none

// Screen store: one write port, one registered read port
module tcw_screen_ram
  import tcw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [CELL_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem_q [CELLS];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/tcw_ctrl.sv =====
`default_nettype none

// Operation sequencer: cursor state, screen sweeps and result assembly
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire cmd_t              cmd_i,
  output logic                   in_ready_o,
  input  wire logic              slot_free_i,
  input  wire logic [CELL_W-1:0] ram_rdata_i,
  output ram_req_t               ram_req_o,
  output logic                   res_valid_o,
  output res_t                   res_o
);

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_FLUSH = 5'b00010,
    S_IDLE  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;

  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  pr_col_q, pr_col_d;
  logic [ROW_W-1:0]  pr_row_q, pr_row_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic              pend_q, pend_d;
  logic              pend_copy_q, pend_copy_d;
  logic              mode_copy_q, mode_copy_d;
  logic              init_q, init_d;
  logic              scrolled_q, scrolled_d;
  logic              rd_ok_q, rd_ok_d;

  logic [UROW_W-1:0] u_row;
  logic [ADDR_W-1:0] u_base;
  logic [ADDR_W-1:0] u_idx;

  logic [COL_W-1:0] bs_col;
  logic             protect;
  logic             col_last;
  logic             row_last;
  logic             copy_now;
  logic             cnt_last;
  logic             col_in_rng;
  logic             row_in_rng;

  tcw_addr_unit u_addr (
    .row_i  (u_row),
    .base_i (u_base),
    .idx_o  (u_idx)
  );

  assign bs_col     = (cur_col_q != '0) ? cur_col_q - COL_W'(1) : cur_col_q;
  assign protect    = (cur_row_q == pr_row_q) && (cur_col_q <= pr_col_q);
  assign col_last   = (cur_col_q == COL_W'(COLUMNS - 1));
  assign row_last   = (cur_row_q == ROW_W'(ROWS - 1));
  assign copy_now   = mode_copy_q && (cnt_q < ADDR_W'(CELLS - COLUMNS));
  assign cnt_last   = (cnt_q == ADDR_W'(CELLS - 1));
  assign col_in_rng = (8'(cmd_q.col) < 8'(COLUMNS));
  assign row_in_rng = (7'(cmd_q.row) < 7'(ROWS));

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    pr_col_d    = pr_col_q;
    pr_row_d    = pr_row_q;
    cnt_d       = cnt_q;
    pend_addr_d = pend_addr_q;
    pend_d      = pend_q;
    pend_copy_d = pend_copy_q;
    mode_copy_d = mode_copy_q;
    init_d      = init_q;
    scrolled_d  = scrolled_q;
    rd_ok_d     = rd_ok_q;
    u_row       = UROW_W'(cur_row_q);
    u_base      = ADDR_W'(cur_col_q);
    ram_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d      = cmd_i;
          scrolled_d = 1'b0;
          rd_ok_d    = 1'b0;
          state_d    = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        case (cmd_q.op)
          OP_PRINT: begin
            if (cmd_q.ch == CH_NEWLINE) begin
              cur_col_d = '0;
              if (row_last) begin
                scrolled_d = 1'b1;
              end else begin
                cur_row_d = cur_row_q + ROW_W'(1);
              end
            end else if (cmd_q.ch == CH_BACKSPACE) begin
              u_base = ADDR_W'(bs_col);
              if (!protect) begin
                cur_col_d       = bs_col;
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = u_idx;
                ram_req_o.wdata = BLANK_CELL;
              end
            end else begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = u_idx;
              ram_req_o.wdata = ATTR_WORD | CELL_W'(cmd_q.ch);
              if (col_last) begin
                cur_col_d = '0;
                if (row_last) begin
                  scrolled_d = 1'b1;
                end else begin
                  cur_row_d = cur_row_q + ROW_W'(1);
                end
              end else begin
                cur_col_d = cur_col_q + COL_W'(1);
              end
            end
            // Cursor ran off the bottom: shift the screen up one row
            if (scrolled_d) begin
              mode_copy_d = 1'b1;
              cnt_d       = '0;
              pend_d      = 1'b0;
              state_d     = S_SWEEP;
            end
          end
          OP_CLEAR: begin
            cur_col_d   = '0;
            cur_row_d   = '0;
            mode_copy_d = 1'b0;
            cnt_d       = '0;
            pend_d      = 1'b0;
            state_d     = S_SWEEP;
          end
          OP_SETCUR: begin
            cur_col_d = col_in_rng ? COL_W'(cmd_q.col) : COL_W'(COLUMNS - 1);
            cur_row_d = row_in_rng ? ROW_W'(cmd_q.row) : ROW_W'(ROWS - 1);
          end
          OP_PROMPT: begin
            pr_col_d = cur_col_q;
            pr_row_d = cur_row_q;
          end
          OP_READ: begin
            u_row         = UROW_W'(cmd_q.row);
            u_base        = ADDR_W'(cmd_q.col);
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = u_idx;
            rd_ok_d         = col_in_rng && row_in_rng;
          end
          default: begin
          end
        endcase
      end

      S_SWEEP: begin
        // Read the cell one row below; its write follows in the next cycle
        u_row           = UROW_W'(1);
        u_base          = cnt_q;
        ram_req_o.re    = copy_now;
        ram_req_o.raddr = u_idx;
        ram_req_o.we    = pend_q;
        ram_req_o.waddr = pend_addr_q;
        ram_req_o.wdata = pend_copy_q ? ram_rdata_i : BLANK_CELL;
        pend_d          = 1'b1;
        pend_addr_d     = cnt_q;
        pend_copy_d     = copy_now;
        cnt_d           = cnt_q + ADDR_W'(1);
        if (cnt_last) begin
          state_d = S_FLUSH;
        end
      end

      S_FLUSH: begin
        ram_req_o.we    = pend_q;
        ram_req_o.waddr = pend_addr_q;
        ram_req_o.wdata = pend_copy_q ? ram_rdata_i : BLANK_CELL;
        pend_d          = 1'b0;
        if (init_q) begin
          init_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free_i) begin
          res_valid_o = 1'b1;
          in_ready_o  = 1'b1;
          if (in_valid_i) begin
            cmd_d      = cmd_i;
            scrolled_d = 1'b0;
            rd_ok_d    = 1'b0;
            state_d    = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.pos      = POS_W'(u_idx);
  assign res_o.data     = rd_ok_q ? ram_rdata_i : '0;
  assign res_o.scrolled = scrolled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      pr_col_q    <= '0;
      pr_row_q    <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_copy_q <= 1'b0;
      mode_copy_q <= 1'b0;
      init_q      <= 1'b1;
      scrolled_q  <= 1'b0;
      rd_ok_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      pr_col_q    <= pr_col_d;
      pr_row_q    <= pr_row_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pend_copy_q <= pend_copy_d;
      mode_copy_q <= mode_copy_d;
      init_q      <= init_d;
      scrolled_q  <= scrolled_d;
      rd_ok_q     <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    pend_addr_q <= pend_addr_d;
  end

endmodule

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// Text console writer: owns an 80 by 25 screen of 16-bit cells (attribute 0x07 above the
// character byte) with a cursor and a prompt mark, and takes one operation per input beat:
// print a byte, clear the screen, set the cursor, mark the prompt, or read a cell. Each
// input beat yields exactly one output beat carrying the linear cursor position, the cell
// word for a read in range (zero otherwise) and a flag for a scroll. After reset the block
// sweeps the whole screen to blanks before it accepts its first beat. Most operations go
// through accept, execute, then a result beat that overlaps the next accept; a read goes
// the same way, its data coming from the registered RAM port. Clear screen and any print
// that scrolls walk every cell through the RAM, one cell a cycle, and hold tready low
// meanwhile. One output beat is buffered, so the next input is accepted while a result
// waits on the master side.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] opcode, [10:3] character, [17:11] column, [22:18] row, [23] zero
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [10:0] cursor_position, [26:11] cell_data, [27] scrolled, [31:28] zero
  output logic      [31:0] m_axis_tdata
);

  cmd_t              cmd;
  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rdata;
  logic              res_valid;
  res_t              res;
  logic              slot_free;

  logic out_valid_q;
  res_t out_q;

  // Unpack the input beat
  assign cmd.op  = s_axis_tdata[2:0];
  assign cmd.ch  = s_axis_tdata[10:3];
  assign cmd.col = s_axis_tdata[17:11];
  assign cmd.row = s_axis_tdata[22:18];

  assign slot_free = !out_valid_q || m_axis_tready;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .cmd_i       (cmd),
    .in_ready_o  (s_axis_tready),
    .slot_free_i (slot_free),
    .ram_rdata_i (ram_rdata),
    .ram_req_o   (ram_req),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tcw_screen_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: load a finished result, drop it once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload while the beat is stalled
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.scrolled, out_q.data, out_q.pos};

  // A new result never overwrites one still waiting on the master side
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || m_axis_tready))
    else $error("result loaded over a pending output beat");

  // Only a print can scroll, and a print never carries cell data
  a_scroll_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.scrolled) |-> (out_q.data == '0))
    else $error("scrolled result carries cell data");

  // Each accepted beat is executed before the next can be taken
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted during execute");

endmodule

`default_nettype wire
